// ===== hdl/blifo_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded LIFO stack package
// Shared widths, operation and error codes, and the control bundle that the
// top level hands to every stack cell.
// ----------------------------------------------------------------------------
package blifo_pkg;

  // Field widths fixed by the interface.
  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int CAP_W  = 6;
  localparam int ERR_W  = 2;

  // Default number of cells and the reset value of the capacity register.
  localparam int DEPTH_DEFAULT = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  // Register map index of the capacity register.
  localparam logic REG_CAPACITY = 1'b0;

  // Operation codes carried by an item.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_TOP    = 3'd3,
    OP_BOTTOM = 3'd4
  } op_t;

  // Error codes returned with each result.
  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_POSITION  = 2'd3
  } err_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // Control shared by all cells in one cycle.
  typedef struct packed {
    logic word_push;  // stored word moves one cell away from the top
    logic word_pop;   // stored word moves one cell towards the top
    logic rd_load;    // copy the stored word into the read chain
    logic rd_shift;   // read chain moves one cell towards the top
  } cell_ctrl_t;

endpackage

// ===== hdl/blifo_cell.sv =====
// ----------------------------------------------------------------------------
// Bounded LIFO stack cell
// Holds one stack entry and one read-chain word. Entries move between
// neighbours on push and pop; the read chain carries deeper entries up to
// the top during a search.
// ----------------------------------------------------------------------------
module blifo_cell
  import blifo_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [WORD_W-1:0] up_word,
  input  logic [WORD_W-1:0] down_word,
  input  logic [WORD_W-1:0] down_rd,
  output logic [WORD_W-1:0] word,
  output logic [WORD_W-1:0] rd
);

  // Stored entry: take the neighbour above on push, below on pop.
  always_ff @(posedge clk) begin
    if (ctrl.word_push) begin
      word <= up_word;
    end else if (ctrl.word_pop) begin
      word <= down_word;
    end
  end

  // Read chain: parallel load, then shift towards the top.
  always_ff @(posedge clk) begin
    if (ctrl.rd_load) begin
      rd <= word;
    end else if (ctrl.rd_shift) begin
      rd <= down_rd;
    end
  end

endmodule

// ===== hdl/bounded_lifo_stack.sv =====
// ----------------------------------------------------------------------------
// Bounded LIFO stack
// Push, pop, read top, read bottom and peek on a row of shift cells whose
// first cell is the top of the stack. Capacity is set over an APB port.
// ----------------------------------------------------------------------------
// Push, pop, read top, errors and unused codes: result in the cycle after accept,
// and a new item can be taken in every cycle.
// Peek at position p > 1 and read bottom with n > 1 entries walk the read chain
// one cell a cycle while busy; the result is registered when the wanted entry
// reaches the second cell. The result strobe cannot be stalled.
// Reset empties the stack and sets capacity to 32; entry contents are undefined.
module bounded_lifo_stack
  import blifo_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  // Command channel
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          opcode,
  input  logic signed [WORD_W-1:0] push_value,
  input  logic [POS_W-1:0]         position,
  // Result channel
  output logic                     strobe,
  output logic signed [WORD_W-1:0] data,
  output logic                     is_empty,
  output logic                     is_full,
  output logic [ERR_W-1:0]         error_code,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [IW-1:0]     left, left_next;
  logic [CAP_W-1:0]  capacity;
  logic [CMPW-1:0]   cap_eff;
  logic [CMPW-1:0]   cnt_x;
  logic [CMPW-1:0]   pos_x;
  logic              accept;
  logic              cfg_write;
  cell_ctrl_t        ctrl;

  logic              strobe_next;
  logic [WORD_W-1:0] data_next;
  logic              is_empty_next;
  logic              is_full_next;
  logic [ERR_W-1:0]  error_next;

  logic [WORD_W-1:0] words [DEPTH];
  logic [WORD_W-1:0] rds   [DEPTH];

  // Configuration register and read-back.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : 32'd0;

  // Effective capacity: zero acts as one, anything above the depth as the depth.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(capacity) > CMPW'(DEPTH)) begin
      cap_eff = CMPW'(DEPTH);
    end else begin
      cap_eff = CMPW'(capacity);
    end
  end

  assign cnt_x  = CMPW'(count);
  assign pos_x  = CMPW'(position);
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Row of cells; the first cell is the top of the stack.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] up_w, down_w, down_r;
    if (i == 0) begin : g_first
      assign up_w = push_value;
    end else begin : g_mid
      assign up_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign down_w = words[i];
      assign down_r = rds[i];
    end else begin : g_inner
      assign down_w = words[i+1];
      assign down_r = rds[i+1];
    end
    blifo_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .up_word   (up_w),
      .down_word (down_w),
      .down_rd   (down_r),
      .word      (words[i]),
      .rd        (rds[i])
    );
  end

  // Sequencer: decodes items, drives the cells and forms each result.
  always_comb begin
    state_next    = state;
    count_next    = count;
    left_next     = left;
    strobe_next   = 1'b0;
    data_next     = data;
    error_next    = error_code;
    is_empty_next = is_empty;
    is_full_next  = is_full;
    ctrl          = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          data_next   = '0;
          error_next  = ERR_OK;
          case (opcode)
            OP_PUSH: begin
              if (cnt_x >= cap_eff) begin
                error_next = ERR_OVERFLOW;
              end else begin
                ctrl.word_push = 1'b1;
                count_next     = count + 1'b1;
              end
            end
            OP_POP: begin
              if (count == '0) begin
                data_next  = '1;
                error_next = ERR_UNDERFLOW;
              end else begin
                ctrl.word_pop = 1'b1;
                data_next     = words[0];
                count_next    = count - 1'b1;
              end
            end
            OP_PEEK: begin
              if (position == '0 || pos_x > cnt_x) begin
                data_next  = '1;
                error_next = ERR_POSITION;
              end else if (position == POS_W'(1)) begin
                data_next = words[0];
              end else begin
                ctrl.rd_load = 1'b1;
                left_next    = IW'(pos_x - CMPW'(1));
                state_next   = ST_SEARCH;
                strobe_next  = 1'b0;
              end
            end
            OP_TOP: begin
              if (count == '0) begin
                data_next  = '1;
                error_next = ERR_UNDERFLOW;
              end else begin
                data_next = words[0];
              end
            end
            OP_BOTTOM: begin
              if (count == '0) begin
                data_next  = '1;
                error_next = ERR_UNDERFLOW;
              end else if (count == CW'(1)) begin
                data_next = words[0];
              end else begin
                ctrl.rd_load = 1'b1;
                left_next    = IW'(count - 1'b1);
                state_next   = ST_SEARCH;
                strobe_next  = 1'b0;
              end
            end
            default: begin
            end
          endcase
          is_empty_next = (count_next == '0);
          is_full_next  = (CMPW'(count_next) >= cap_eff);
        end
      end
      ST_SEARCH: begin
        // Each cycle brings the wanted entry one cell closer to the top.
        ctrl.rd_shift = 1'b1;
        left_next     = left - 1'b1;
        if (left == IW'(1)) begin
          data_next   = rds[1];
          strobe_next = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      left   <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      left   <= left_next;
      strobe <= strobe_next;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    data       <= data_next;
    error_code <= error_next;
    is_empty   <= is_empty_next;
    is_full    <= is_full_next;
  end

  // The entry count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(count) <= CMPW'(DEPTH))
    else $error("entry count above depth");

  // A search always has at least one step left to run.
  a_search_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (left != '0))
    else $error("search running with no steps left");

  // An accepted push that fits raises the count by one.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_PUSH && cnt_x < cap_eff) |=> (count == $past(count) + 1'b1))
    else $error("push did not raise the count");

  // Overflow is reported only on a full stack, underflow only on an empty one.
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (strobe && error_code == ERR_OVERFLOW) |-> is_full)
    else $error("overflow reported on a stack that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    (strobe && error_code == ERR_UNDERFLOW) |-> is_empty)
    else $error("underflow reported on a stack that is not empty");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Bounded LIFO stack testbench
// Drives push, pop, peek, top, bottom and unused operation items through the
// start/busy command port, rewrites the capacity register over APB between
// phases, and checks every result strobe against a cycle-free stack predictor
// or a hand-written expectation.
module tb_top;
  import blifo_pkg::*;

  localparam int          HALF_PERIOD  = 2;
  localparam int          RESET_CYCLES = 9;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int          SETTLE       = 40;
  localparam int          PHASES       = 13;
  localparam int          PHASE_ITEMS  = 150;
  localparam int          IDLE_PCT     = 13;

  // Opcodes outside the defined set, which must leave the stack untouched.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // Byte address of the capacity register.
  localparam logic [2:0] CAP_ADDR = 3'(4 * int'(REG_CAPACITY));

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic                     empty;
    logic                     full;
    err_t                     err;
  } stack_result_t;

  // One line of the directed table: either an operation item or a new capacity.
  typedef struct {
    logic              is_cfg;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic              typed;
    stack_result_t     res;
  } stim_row_t;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     start      = 1'b0;
  logic                     busy;
  logic [OP_W-1:0]          opcode     = '0;
  logic signed [WORD_W-1:0] push_value = '0;
  logic [POS_W-1:0]         position   = '0;
  logic                     strobe;
  logic signed [WORD_W-1:0] data;
  logic                     is_empty;
  logic                     is_full;
  logic [ERR_W-1:0]         error_code;
  logic                     psel       = 1'b0;
  logic                     penable    = 1'b0;
  logic                     pwrite     = 1'b0;
  logic [2:0]               paddr      = '0;
  logic [31:0]              pwdata     = '0;
  logic [31:0]              prdata;
  logic                     pready;

  // Hand-written expectation travelling alongside the item being offered.
  logic                     row_typed  = 1'b0;
  stack_result_t            row_expect = '0;

  // Predictor state.
  logic signed [WORD_W-1:0] stack_words [DEPTH_DEFAULT];
  int                       stack_count  = 0;
  logic [CAP_W-1:0]         capacity_reg = CAP_RESET;

  stack_result_t            pending_results [$];
  stim_row_t                directed_rows [$];
  int unsigned              cycle_count = 0;
  int                       mismatches  = 0;
  bit                       allow_idle  = 1'b1;

  bounded_lifo_stack uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .push_value (push_value),
    .position   (position),
    .strobe     (strobe),
    .data       (data),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .error_code (error_code),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Applies one operation to the predicted stack and returns its result.
  function automatic stack_result_t apply_stack_op(logic [OP_W-1:0] op,
                                                   logic signed [WORD_W-1:0] word,
                                                   logic [POS_W-1:0] pos);
    stack_result_t res;
    int            limit;
    limit = (capacity_reg == 0) ? 1 :
            (int'(capacity_reg) > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(capacity_reg);
    res = '{data: '0, empty: 1'b0, full: 1'b0, err: ERR_OK};
    case (op)
      OP_PUSH: begin
        if (stack_count >= limit) begin
          res.err = ERR_OVERFLOW;
        end else begin
          stack_words[stack_count] = word;
          stack_count++;
        end
      end
      OP_POP: begin
        if (stack_count == 0) begin
          res.data = -1;
          res.err  = ERR_UNDERFLOW;
        end else begin
          stack_count--;
          res.data = stack_words[stack_count];
        end
      end
      OP_PEEK: begin
        if (pos == 0 || int'(pos) > stack_count) begin
          res.data = -1;
          res.err  = ERR_POSITION;
        end else begin
          res.data = stack_words[stack_count - int'(pos)];
        end
      end
      OP_TOP, OP_BOTTOM: begin
        if (stack_count == 0) begin
          res.data = -1;
          res.err  = ERR_UNDERFLOW;
        end else begin
          res.data = (op == OP_TOP) ? stack_words[stack_count - 1] : stack_words[0];
        end
      end
      default: begin
      end
    endcase
    res.empty = (stack_count == 0);
    res.full  = (stack_count >= limit);
    return res;
  endfunction

  // Result checking, register shadowing and item capture, all on the same edge.
  always @(posedge clk) begin : monitor
    stack_result_t want;
    stack_result_t pred;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (!rst) begin
      if (strobe) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result at cycle %0d: data %h", cycle_count, data);
        end else begin
          want = pending_results.pop_front();
          if (data !== want.data || is_empty !== want.empty || is_full !== want.full ||
              error_code !== want.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at cycle %0d: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
                       cycle_count, want.data, want.empty, want.full, want.err,
                       data, is_empty, is_full, error_code);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
        capacity_reg = pwdata[CAP_W-1:0];
      if (start && !busy) begin
        pred = apply_stack_op(opcode, push_value, position);
        pending_results.push_back(row_typed ? row_expect : pred);
      end
    end
  end

  // Adds one line to the directed table.
  task automatic add_row(logic is_cfg, logic [OP_W-1:0] op, logic [WORD_W-1:0] value,
                         logic [POS_W-1:0] pos, logic typed, logic [WORD_W-1:0] rdata,
                         logic rempty, logic rfull, err_t rerr);
    stim_row_t row;
    row.is_cfg = is_cfg;
    row.op     = op;
    row.value  = value;
    row.pos    = pos;
    row.typed  = typed;
    row.res    = '{data: rdata, empty: rempty, full: rfull, err: rerr};
    directed_rows.push_back(row);
  endtask

  // Offers one item, idling first now and then, and returns once it is taken.
  task automatic send_op(logic [OP_W-1:0] op, logic [WORD_W-1:0] value,
                         logic [POS_W-1:0] pos, logic typed, stack_result_t res);
    while (allow_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    opcode     <= op;
    push_value <= value;
    position   <= pos;
    row_typed  <= typed;
    row_expect <= res;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Stops offering items and waits until every result is back.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  // Writes the capacity register once the stack is idle.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CAP_ADDR;
    pwdata  <= 32'(cap);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stimulus: directed table first, then random phases at varying capacities.
  initial begin : stimulus
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic [CAP_W-1:0]  cap;
    int                push_pct;
    int                r;

    // Empty-stack errors, unused opcodes, extreme words and peek bounds.
    add_row(0, OP_POP,       '0,           0,  1, 32'hFFFFFFFF, 1, 0, ERR_UNDERFLOW);
    add_row(0, OP_TOP,       '0,           0,  1, 32'hFFFFFFFF, 1, 0, ERR_UNDERFLOW);
    add_row(0, OP_BOTTOM,    '0,           0,  1, 32'hFFFFFFFF, 1, 0, ERR_UNDERFLOW);
    add_row(0, OP_PEEK,      '0,           1,  1, 32'hFFFFFFFF, 1, 0, ERR_POSITION);
    add_row(0, OP_SPARE_LO,  32'hFFFFFFFF, 63, 1, 32'h0,        1, 0, ERR_OK);
    add_row(0, OP_SPARE_HI,  32'hFFFFFFFF, 63, 1, 32'h0,        1, 0, ERR_OK);
    add_row(0, OP_PUSH,      32'h7FFFFFFF, 0,  1, 32'h0,        0, 0, ERR_OK);
    add_row(0, OP_PUSH,      32'h80000000, 0,  1, 32'h0,        0, 0, ERR_OK);
    add_row(0, OP_PUSH,      32'hFFFFFFFF, 0,  1, 32'h0,        0, 0, ERR_OK);
    add_row(0, OP_TOP,       '0,           0,  0, '0,           0, 0, ERR_OK);
    add_row(0, OP_BOTTOM,    '0,           0,  1, 32'h7FFFFFFF, 0, 0, ERR_OK);
    add_row(0, OP_PEEK,      '0,           0,  1, 32'hFFFFFFFF, 0, 0, ERR_POSITION);
    add_row(0, OP_PEEK,      '0,           3,  0, '0,           0, 0, ERR_OK);
    add_row(0, OP_PEEK,      '0,           4,  1, 32'hFFFFFFFF, 0, 0, ERR_POSITION);
    add_row(0, OP_PEEK,      '0,           63, 1, 32'hFFFFFFFF, 0, 0, ERR_POSITION);
    add_row(0, OP_POP,       '0,           0,  0, '0,           0, 0, ERR_OK);
    add_row(0, OP_SPARE_MID, 32'h12345678, 5,  0, '0,           0, 0, ERR_OK);
    // Capacity brought down to the count, then below it, then above the depth.
    add_row(1, OP_PUSH,      32'd2,        0,  0, '0,           0, 0, ERR_OK);
    add_row(0, OP_PUSH,      32'h12345678, 0,  1, 32'h0,        0, 1, ERR_OVERFLOW);
    add_row(1, OP_PUSH,      32'd0,        0,  0, '0,           0, 0, ERR_OK);
    add_row(0, OP_POP,       '0,           0,  0, '0,           0, 0, ERR_OK);
    add_row(0, OP_PUSH,      32'h0000FFFF, 0,  1, 32'h0,        0, 1, ERR_OVERFLOW);
    add_row(1, OP_PUSH,      32'd63,       0,  0, '0,           0, 0, ERR_OK);
    add_row(0, OP_PUSH,      32'h5A5AA5A5, 0,  0, '0,           0, 0, ERR_OK);
    add_row(0, OP_POP,       '0,           0,  0, '0,           0, 0, ERR_OK);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_capacity(directed_rows[i].value[CAP_W-1:0]);
      else
        send_op(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pos,
                directed_rows[i].typed, directed_rows[i].res);
    end

    // Random phases: first fill a full-size stack, then raise the capacity above
    // the depth, then shrink it under the stored entries, then wander through random capacities.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       cap = CAP_W'(32);
        1:       cap = CAP_W'(63);
        2:       cap = CAP_W'(0);
        3:       cap = CAP_W'(1);
        default: cap = CAP_W'($urandom_range(0, 63));
      endcase
      write_capacity(cap);
      push_pct   = (ph == 0) ? 75 : int'($urandom_range(35, 65));
      allow_idle = !(ph == 5 || ph == 6);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        value = $urandom();
        r     = $urandom_range(0, 9);
        if (r == 0) value = 32'h80000000;
        else if (r == 1) value = 32'h7FFFFFFF;
        else if (r == 2) value = 32'hFFFFFFFF;
        pos = POS_W'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < push_pct) begin
          op = OP_PUSH;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 30) op = OP_POP;
          else if (r < 60) op = OP_PEEK;
          else if (r < 75) op = OP_TOP;
          else if (r < 92) op = OP_BOTTOM;
          else op = OP_W'($urandom_range(5, 7));
        end
        // Most peeks land inside the stack; the rest probe its edges or a random position.
        if (op == OP_PEEK) begin
          r = $urandom_range(0, 99);
          if (r < 70) pos = POS_W'($urandom_range(1, (stack_count > 0) ? stack_count : 1));
          else if (r < 80) pos = '0;
          else if (r < 90) pos = POS_W'(stack_count + 1);
        end
        send_op(op, value, pos, 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/blifo_pkg.sv
hdl/blifo_cell.sv
hdl/bounded_lifo_stack.sv
bench/tb_top.sv
